// ===== rtl/tsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsw_pkg;

   localparam int DIM_W      = 11;
   localparam int DIM_MIN    = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SECOND_PASS  = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic             second_pass;
   } cfg_type;

   typedef struct packed {
      logic pixel;
      logic has_result;
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } pos_type;

   typedef struct packed {
      logic pixel_out;
      logic deleted;
      logic frame_last;
      logic any_deleted;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/thinning_subpass_window_top.sv =====
// A result is pushed into the result queue from the stage register of the transaction
// that completes its window, which is frame_width+1 pixels after its own.
// Throughput: one pixel per cycle, set by the single read-modify-write of the line
// memory per pixel and the four-entry result queue; req_stall holds input while full.
// Reset: synchronous; width and height 1024, first sub-pass, position and flag
// cleared; the line memory is not cleared since border rows are masked.
`timescale 1ns / 1ps
`default_nettype none

module thinning_subpass_window_top
   import tsw_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_pixel_in,
   input  wire logic                  req_drain,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_pixel_out,
   output logic                       rsp_deleted,
   output logic                       rsp_frame_last,
   output logic                       rsp_any_deleted,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT + 2);
   localparam int MAXW = (CW > RW) ? CW : RW;
   localparam int EW   = ((MAXW > DIM_W) ? MAXW : DIM_W) + 2;

   cfg_type        cfg;
   logic           restart;
   logic           accept, can_take;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [EW-1:0]  r_x, c_x, w_x, h_x, cr_x, cc_x;
   logic           col_zero;
   pos_type        pos;

   logic           stage_valid_ff;
   pos_type        stage_ff;
   logic [CW-1:0]  stage_col_ff;
   logic [1:0]     line_col;
   result_type     result, rsp_data;

   tsw_csr #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg),
      .restart(restart)
   );

   assign req_stall = ~can_take;
   assign accept    = req_valid & can_take;

   assign r_x      = EW'(row_ff);
   assign c_x      = EW'(col_ff);
   assign w_x      = EW'(cfg.frame_width);
   assign h_x      = EW'(cfg.frame_height);
   assign col_zero = (col_ff == '0);
   assign cr_x     = col_zero ? (r_x - EW'(2)) : (r_x - EW'(1));
   assign cc_x     = col_zero ? (w_x - EW'(1)) : (c_x - EW'(1));

   always_comb begin
      pos.pixel      = req_pixel_in & ~req_drain & ~(r_x >= h_x);
      pos.has_result = ~((row_ff == '0) || ((row_ff == RW'(1)) && col_zero));
      pos.top        = (cr_x == '0);
      pos.bottom     = (cr_x + EW'(1)) >= h_x;
      pos.left       = (cc_x == '0);
      pos.right      = (cc_x + EW'(1)) >= w_x;
      pos.last       = pos.has_result & pos.bottom & pos.right;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (pos.last) begin
            col_in = '0;
            row_in = '0;
         end else if ((c_x + EW'(1)) >= w_x) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff     <= pos;
         stage_col_ff <= col_ff;
      end
   end

   tsw_ram #(
      .WIDTH(2),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (stage_valid_ff),
      .wr_addr(stage_col_ff),
      .wr_data({stage_ff.pixel, line_col[1]}),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(line_col)
   );

   tsw_kernel u_kernel (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .stage_valid(stage_valid_ff),
      .stage      (stage_ff),
      .line_col   (line_col),
      .second_pass(cfg.second_pass),
      .result     (result)
   );

   tsw_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (stage_valid_ff & stage_ff.has_result),
      .push_data(result),
      .reserved (stage_valid_ff),
      .can_take (can_take),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (rsp_data)
   );

   assign rsp_pixel_out   = rsp_data.pixel_out;
   assign rsp_deleted     = rsp_data.deleted;
   assign rsp_frame_last  = rsp_data.frame_last;
   assign rsp_any_deleted = rsp_data.any_deleted;

endmodule

`default_nettype wire

// ===== rtl/tsw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsw_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tsw_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsw_csr
   import tsw_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg,
   output logic                       restart
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int EW      = (($clog2(MAX_DIM) > DIM_W) ? $clog2(MAX_DIM) : DIM_W) + 2;
   localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

   cfg_type          cfg_ff, cfg_in;
   logic             wr_en;
   logic [EW-1:0]    wdata_x;
   logic [DIM_W-1:0] width_clamp, height_clamp;

   assign wr_en   = psel & penable & pwrite;
   assign wdata_x = EW'(pwdata[DIM_W-1:0]);

   always_comb begin
      if (wdata_x < EW'(DIM_MIN)) begin
         width_clamp = DIM_W'(DIM_MIN);
      end else if (wdata_x > EW'(MAX_WIDTH)) begin
         width_clamp = DIM_W'(MAX_WIDTH);
      end else begin
         width_clamp = pwdata[DIM_W-1:0];
      end
      if (wdata_x < EW'(DIM_MIN)) begin
         height_clamp = DIM_W'(DIM_MIN);
      end else if (wdata_x > EW'(MAX_HEIGHT)) begin
         height_clamp = DIM_W'(MAX_HEIGHT);
      end else begin
         height_clamp = pwdata[DIM_W-1:0];
      end
   end

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (wr_en) begin
         case (paddr[3:2])
            REG_FRAME_WIDTH: begin
               cfg_in.frame_width = width_clamp;
               restart            = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               cfg_in.frame_height = height_clamp;
               restart             = 1'b1;
            end
            REG_SECOND_PASS: begin
               cfg_in.second_pass = pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= DIM_W'(W_RESET);
         cfg_ff.frame_height <= DIM_W'(H_RESET);
         cfg_ff.second_pass  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_SECOND_PASS:  prdata = CSR_DATA_W'(cfg_ff.second_pass);
         default:          prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/tsw_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsw_kernel
   import tsw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       restart,
   input  wire logic       stage_valid,
   input  pos_type         stage,
   input  wire logic [1:0] line_col,
   input  wire logic       second_pass,
   output result_type      result
);

   localparam int SUM_LO = 2;
   localparam int SUM_HI = 6;

   logic [8:0] window_ff, window_in;
   logic       seen_ff, seen_in;
   logic [7:0] p;
   logic [3:0] sum, trans;
   logic       cond_a, cond_b, centre, del;

   assign window_in = {stage.pixel, line_col[1], line_col[0], window_ff[8:3]};
   assign centre    = window_in[4];

   always_comb begin
      p[0] = window_in[3];
      p[1] = window_in[6];
      p[2] = window_in[7];
      p[3] = window_in[8];
      p[4] = window_in[5];
      p[5] = window_in[2];
      p[6] = window_in[1];
      p[7] = window_in[0];
      if (stage.top) begin
         p[7] = 1'b0;
         p[0] = 1'b0;
         p[1] = 1'b0;
      end
      if (stage.bottom) begin
         p[3] = 1'b0;
         p[4] = 1'b0;
         p[5] = 1'b0;
      end
      if (stage.left) begin
         p[5] = 1'b0;
         p[6] = 1'b0;
         p[7] = 1'b0;
      end
      if (stage.right) begin
         p[1] = 1'b0;
         p[2] = 1'b0;
         p[3] = 1'b0;
      end
   end

   always_comb begin
      sum   = '0;
      trans = '0;
      for (int i = 0; i < 8; i++) begin
         sum   = sum + 4'(p[i]);
         trans = trans + 4'(~p[i] & p[(i + 1) % 8]);
      end
   end

   always_comb begin
      if (second_pass) begin
         cond_a = ~(p[0] & p[2] & p[6]);
         cond_b = ~(p[0] & p[4] & p[6]);
      end else begin
         cond_a = ~(p[0] & p[2] & p[4]);
         cond_b = ~(p[2] & p[4] & p[6]);
      end
   end

   assign del = centre & (sum >= 4'(SUM_LO)) & (sum <= 4'(SUM_HI)) & (trans == 4'd1)
              & cond_a & cond_b;

   always_comb begin
      seen_in = seen_ff;
      if (restart) begin
         seen_in = 1'b0;
      end else if (stage_valid && stage.has_result) begin
         seen_in = stage.last ? 1'b0 : (seen_ff | del);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= 1'b0;
      end else begin
         if (stage_valid) begin
            window_ff <= window_in;
         end
         seen_ff <= seen_in;
      end
   end

   assign result.pixel_out   = centre & ~del;
   assign result.deleted     = del;
   assign result.frame_last  = stage.last;
   assign result.any_deleted = seen_ff | del;

endmodule

`default_nettype wire

// ===== rtl/tsw_rsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsw_rsp_fifo
   import tsw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  result_type push_data,
   input  wire logic reserved,
   output logic      can_take,
   output logic      out_valid,
   input  wire logic out_stall,
   output result_type out_data
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = PW + 1;

   result_type        slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid & ~out_stall;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign can_take  = (count_ff + CNTW'(reserved)) < CNTW'(DEPTH);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/thinning_subpass_window_top_test.sv =====
`timescale 1ns / 1ps

module thinning_subpass_window_top_test;
   import tsw_pkg::*;

   localparam int unsigned MAX_W = 1024;
   localparam int unsigned MAX_H = 1024;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_PIXELS = 720;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic pixel;
      logic drain;
   } pixel_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_pixel_in = 1'b0;
   logic req_drain = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_pixel_out;
   logic rsp_deleted;
   logic rsp_frame_last;
   logic rsp_any_deleted;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   pixel_item_type pending_pixels[$];
   result_type expected_results[$];
   int unsigned pixels_queued = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int unsigned send_gap = 0;
   bit send_burst = 1'b0;
   int unsigned recv_wait = 0;
   bit recv_burst = 1'b0;
   int unsigned hold_left = 0;
   bit hold_request = 1'b0;

   // thinning state
   int unsigned frame_w = MAX_W;
   int unsigned frame_h = MAX_H;
   logic second_pass = 1'b0;
   bit [MAX_W-1:0] up_line = '0;
   bit [MAX_W-1:0] mid_line = '0;
   logic [8:0] window = '0;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   logic del_seen = 1'b0;

   thinning_subpass_window_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_in(req_pixel_in),
      .req_drain(req_drain),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_deleted(rsp_deleted),
      .rsp_frame_last(rsp_frame_last),
      .rsp_any_deleted(rsp_any_deleted),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned clamp_dimension(logic [31:0] value, int unsigned top);
      int unsigned v;
      v = value & 32'h7FF;
      if (v < DIM_MIN) return DIM_MIN;
      if (v > top) return top;
      return v;
   endfunction

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      del_seen = 1'b0;
   endtask

   task automatic apply_register(logic [1:0] index, logic [31:0] value);
      case (index)
         REG_FRAME_WIDTH: begin
            frame_w = clamp_dimension(value, MAX_W);
            restart_frame();
         end
         REG_FRAME_HEIGHT: begin
            frame_h = clamp_dimension(value, MAX_H);
            restart_frame();
         end
         REG_SECOND_PASS: begin
            second_pass = value[0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic thin_step(logic pixel_in, logic drain_in);
      int unsigned r, c, idx, cr, cc, ones, rises;
      logic pix, rule_a, rule_b, remove, last, center;
      logic [2:0] column;
      logic [7:0] ring;
      result_type res;
      r = row_pos;
      c = col_pos;
      idx = (c < MAX_W) ? c : 0;
      pix = pixel_in && !drain_in && (r < frame_h);
      column = {pix, mid_line[idx], up_line[idx]};
      up_line[idx] = mid_line[idx];
      mid_line[idx] = pix;
      window = {column, window[8:3]};
      if (c + 1 >= frame_w) begin
         col_pos = 0;
         row_pos = (r + 1) & 32'h7FF;
      end else begin
         col_pos = c + 1;
      end
      if (r == 0 || (r == 1 && c == 0)) return;
      if (c == 0) begin
         cr = r - 2;
         cc = frame_w - 1;
      end else begin
         cr = r - 1;
         cc = c - 1;
      end
      // neighbors clockwise from north
      ring = {window[0], window[1], window[2], window[5],
              window[8], window[7], window[6], window[3]};
      if (cr == 0) begin
         ring[7] = 1'b0; ring[0] = 1'b0; ring[1] = 1'b0;
      end
      if (cr + 1 >= frame_h) begin
         ring[3] = 1'b0; ring[4] = 1'b0; ring[5] = 1'b0;
      end
      if (cc == 0) begin
         ring[5] = 1'b0; ring[6] = 1'b0; ring[7] = 1'b0;
      end
      if (cc + 1 >= frame_w) begin
         ring[1] = 1'b0; ring[2] = 1'b0; ring[3] = 1'b0;
      end
      ones = 0;
      rises = 0;
      for (int i = 0; i < 8; i++) begin
         ones += ring[i];
         if (!ring[i] && ring[(i + 1) % 8]) rises++;
      end
      if (second_pass) begin
         rule_a = !(ring[0] && ring[2] && ring[6]);
         rule_b = !(ring[0] && ring[4] && ring[6]);
      end else begin
         rule_a = !(ring[0] && ring[2] && ring[4]);
         rule_b = !(ring[2] && ring[4] && ring[6]);
      end
      center = window[4];
      remove = center && ones >= 2 && ones <= 6 && rises == 1 && rule_a && rule_b;
      del_seen = del_seen | remove;
      last = (cr + 1 >= frame_h) && (cc + 1 >= frame_w);
      res.pixel_out = center && !remove;
      res.deleted = remove;
      res.frame_last = last;
      res.any_deleted = del_seen;
      expected_results.insert(expected_results.size(), res);
      if (last) restart_frame();
   endtask

   task automatic note_mismatch(string what, result_type want, result_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t %0s: expected pixel_out=%0b deleted=%0b frame_last=%0b any_deleted=%0b,",
                  $realtime, what, want.pixel_out, want.deleted, want.frame_last,
                  want.any_deleted);
         $display("   got pixel_out=%0b deleted=%0b frame_last=%0b any_deleted=%0b",
                  got.pixel_out, got.deleted, got.frame_last, got.any_deleted);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      result_type got, want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_pixel_out, rsp_deleted, rsp_frame_last, rsp_any_deleted};
         if (expected_results.size() == 0) begin
            note_mismatch("transaction with nothing expected", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got.pixel_out !== want.pixel_out || got.deleted !== want.deleted ||
                got.frame_last !== want.frame_last ||
                got.any_deleted !== want.any_deleted)
               note_mismatch("mismatch", want, got);
         end
      end
      if (!reset && req_valid && !req_stall) thin_step(req_pixel_in, req_drain);
   end

   always @(negedge clock) begin : driver
      pixel_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_pixels.size() != 0) begin
            next_item = pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_pixel_in <= next_item.pixel;
            req_drain <= next_item.drain;
            if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
            send_gap <= send_burst ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int unsigned wait_draw;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_taken) begin
         if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
         wait_draw = recv_burst ? 0 : $urandom_range(0, 6);
         recv_wait <= wait_draw;
         rsp_stall <= (wait_draw != 0);
      end else if (recv_wait != 0) begin
         recv_wait <= recv_wait - 1;
         rsp_stall <= (recv_wait > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pwrite && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_register(index, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(logic [1:0] index, logic [31:0] want);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t register %0d: expected %0h, got %0h",
                     $realtime, index, want, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic settle();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pixel(logic pixel, logic drain);
      pixel_item_type item;
      item.pixel = pixel;
      item.drain = drain;
      pending_pixels.insert(pending_pixels.size(), item);
      pixels_queued++;
   endtask

   task automatic queue_frame(int unsigned w, int unsigned h, int unsigned density, bit junk);
      for (int unsigned k = 0; k < w * h; k++) begin
         if (junk && $urandom_range(0, 7) == 0)
            queue_pixel($urandom_range(0, 1), 1'b1);
         else
            queue_pixel($urandom_range(0, 99) < density, 1'b0);
      end
      for (int unsigned k = 0; k <= w; k++)
         queue_pixel(junk ? $urandom_range(0, 1) : 1'b0, 1'b1);
   endtask

   function automatic logic [31:0] pick_dimension();
      logic [31:0] junk_bits;
      junk_bits = $urandom & 32'hFFFF_F800;
      case ($urandom_range(0, 7))
         0: return junk_bits | $urandom_range(0, 2);
         1: return junk_bits | $urandom_range(3, 8);
         default: return $urandom_range(3, 8);
      endcase
   endfunction

   initial begin : stimulus
      logic [8:0] pattern;
      int unsigned random_start, phase, frames, density;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      csr_write(REG_FRAME_WIDTH, 32'hFFFF_F800);
      csr_write(REG_FRAME_HEIGHT, 32'd2);
      csr_write(REG_SECOND_PASS, 32'd0);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      @(posedge clock);
      for (int k = 0; k < 9; k++) queue_pixel(1'b1, 1'b0);
      for (int k = 0; k < 4; k++) queue_pixel(1'b1, 1'b1);
      settle();

      csr_write(REG_SECOND_PASS, 32'hFFFF_FFFF);
      @(posedge clock);
      pattern = 9'b111_111_110;
      for (int k = 0; k < 9; k++) begin
         if (k == 7) queue_pixel(1'b1, 1'b1);
         else queue_pixel(pattern[k], 1'b0);
      end
      for (int k = 0; k < 4; k++) queue_pixel(1'b0, 1'b1);
      settle();

      csr_write(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
      csr_write(REG_FRAME_HEIGHT, 32'hFFFF_FFFF);
      csr_write(REG_SECOND_PASS, 32'd0);
      csr_check(REG_FRAME_WIDTH, frame_w);
      csr_check(REG_FRAME_HEIGHT, frame_h);
      csr_check(REG_SECOND_PASS, 32'(second_pass));
      @(posedge clock);
      repeat (40) queue_pixel($urandom_range(0, 1), 1'b0);
      settle();

      csr_write(REG_FRAME_WIDTH, 32'd3);
      csr_write(REG_FRAME_HEIGHT, 32'd1024);
      csr_write(REG_SECOND_PASS, 32'd1);
      @(posedge clock);
      repeat (60) queue_pixel($urandom_range(0, 99) < 60, 1'b0);

      random_start = pixels_queued;
      phase = 0;
      while (pixels_queued < random_start + RANDOM_PIXELS) begin
         settle();
         if (phase == 0 || $urandom_range(0, 9) < 7) begin
            csr_write(REG_FRAME_WIDTH, pick_dimension());
            csr_write(REG_FRAME_HEIGHT, pick_dimension());
         end
         if ($urandom_range(0, 1)) csr_write(REG_SECOND_PASS, $urandom);
         @(posedge clock);
         frames = (phase == 3) ? 6 : $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            if (phase != 3 && $urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 20))
                  queue_pixel($urandom_range(0, 1), $urandom_range(0, 3) == 0);
            end else begin
               case ($urandom_range(0, 3))
                  0: density = 30;
                  1: density = 50;
                  2: density = 70;
                  default: density = 85;
               endcase
               queue_frame(frame_w, frame_h, density, phase != 3 && $urandom_range(0, 7) == 0);
            end
         end
         // hold the receiver so the result queue fills and the input stalls
         if (phase == 3) hold_request = 1'b1;
         phase++;
      end

      settle();
      error_count += expected_results.size();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tsw_pkg.sv
rtl/tsw_ram.sv
rtl/tsw_csr.sv
rtl/tsw_kernel.sv
rtl/tsw_rsp_fifo.sv
rtl/thinning_subpass_window_top.sv
bench/thinning_subpass_window_top_test.sv
